[hw/rtl/bsfe_pkg.sv]
// Package for the byte stack frame engine: sizes, opcodes, status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package bsfe_pkg;

  localparam int STACK_SIZE     = 4096;
  localparam int HANDLER_OFFSET = 2;
  localparam int MAX_FRAMES     = 256;

  localparam int MEM_AW  = $clog2(STACK_SIZE);      // byte memory index
  localparam int PTR_W   = 13;                      // pointer / address field width
  localparam int WORD_W  = 16;                      // data and link word width
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 4;
  localparam int ST_W    = 2;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int IN_W    = OP_W + WORD_W + PTR_W + PTR_W;  // 46 used bits
  localparam int IN_BUS  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = WORD_W + PTR_W + ST_W + 1;      // 32 bits
  localparam int OUT_BUS = ((OUT_W + 7) / 8) * 8;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUSH8    = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH16   = 4'd1;
  localparam logic [OP_W-1:0] OP_POP8     = 4'd2;
  localparam logic [OP_W-1:0] OP_POP16    = 4'd3;
  localparam logic [OP_W-1:0] OP_MARK_AUX = 4'd4;
  localparam logic [OP_W-1:0] OP_POP_AUX8 = 4'd5;
  localparam logic [OP_W-1:0] OP_READ16   = 4'd6;
  localparam logic [OP_W-1:0] OP_READ8    = 4'd7;
  localparam logic [OP_W-1:0] OP_WRITE16  = 4'd8;
  localparam logic [OP_W-1:0] OP_FIND     = 4'd9;

  // result status
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_OVF   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNF   = 2'd2;
  localparam logic [ST_W-1:0] ST_LIMIT = 2'd3;

  // memory address select
  localparam logic [3:0] MA_SP     = 4'd0;
  localparam logic [3:0] MA_SP_P1  = 4'd1;
  localparam logic [3:0] MA_SP_M1  = 4'd2;
  localparam logic [3:0] MA_SP_M2  = 4'd3;
  localparam logic [3:0] MA_AUX    = 4'd4;
  localparam logic [3:0] MA_ADDR   = 4'd5;
  localparam logic [3:0] MA_ADDR_P1 = 4'd6;
  localparam logic [3:0] MA_ADDR_M1 = 4'd7;
  localparam logic [3:0] MA_FP     = 4'd8;
  localparam logic [3:0] MA_FP_P1  = 4'd9;
  localparam logic [3:0] MA_FP_H   = 4'd10;
  localparam logic [3:0] MA_FP_H1  = 4'd11;

  // stack pointer update
  localparam logic [2:0] SP_HOLD = 3'd0;
  localparam logic [2:0] SP_INC1 = 3'd1;
  localparam logic [2:0] SP_INC2 = 3'd2;
  localparam logic [2:0] SP_DEC1 = 3'd3;
  localparam logic [2:0] SP_DEC2 = 3'd4;

  // result data select
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_BYTE = 2'd1;
  localparam logic [1:0] RES_WORD = 2'd2;

  typedef struct packed {
    logic             load;       // latch input beat
    logic             mem_we;
    logic             mem_re;
    logic [3:0]       ma_sel;
    logic             wd_hi;      // write high byte of value
    logic [2:0]       sp_op;
    logic             aux_mark;
    logic             aux_inc;
    logic             hi_load;    // keep read byte as high half of word
    logic             fp_link;    // follow frame link, bump link count
    logic             res_load;
    logic [1:0]       res_sel;
    logic [ST_W-1:0]  res_status;
    logic             res_found;
    logic             out_load;
  } bsfe_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             sp_ge1;
    logic             sp_ge2;
    logic             sp_lt;
    logic             sp_word_ok;
    logic             aux_lt;
    logic             addr_lt;
    logic             addr_word_ok;
    logic             addr_wr_ok;
    logic             fp_zero;
    logic             cnt_max;
    logic             fp_h_ok;
    logic             fp_ok;
    logic             word_nz;
    logic [PTR_W-1:0] sp;
    logic [PTR_W-1:0] aux;
    logic [CNT_W-1:0] cnt;
  } bsfe_stat_t;

endpackage

[hw/rtl/bsfe_dpath.sv]
// Datapath: byte stack memory, stack/aux pointers, frame walk registers,
// result and output registers. Depends on bsfe_pkg.
module bsfe_dpath
  import bsfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [IN_W-1:0]    in_data,
  input  bsfe_cmd_t          cmd,
  output bsfe_stat_t         stat,
  output logic [OUT_W-1:0]   out_data
);

  localparam logic [PTR_W-1:0]  SIZE_P  = PTR_W'(STACK_SIZE);
  localparam logic [WORD_W:0]   SIZE_W  = (WORD_W + 1)'(STACK_SIZE);
  localparam logic [WORD_W:0]   HOFS    = (WORD_W + 1)'(HANDLER_OFFSET);

  logic [BYTE_W-1:0] mem [STACK_SIZE];

  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] val;
  logic [PTR_W-1:0]  addr;
  logic [WORD_W-1:0] fp;
  logic [CNT_W-1:0]  cnt;
  logic [PTR_W-1:0]  sp;
  logic [PTR_W-1:0]  aux;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] hi;
  logic [WORD_W-1:0] res_data;
  logic [ST_W-1:0]   res_status;
  logic              res_found;

  logic [WORD_W:0]   ma_w;
  logic [MEM_AW-1:0] ma;
  logic [BYTE_W-1:0] wd;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] res_next;

  assign word = {hi, rd_data};
  assign wd   = cmd.wd_hi ? val[WORD_W-1:BYTE_W] : val[BYTE_W-1:0];

  always_comb begin
    unique case (cmd.ma_sel)
      MA_SP:      ma_w = (WORD_W + 1)'(sp);
      MA_SP_P1:   ma_w = (WORD_W + 1)'(sp) + 1'b1;
      MA_SP_M1:   ma_w = (WORD_W + 1)'(sp) - 1'b1;
      MA_SP_M2:   ma_w = (WORD_W + 1)'(sp) - 2'd2;
      MA_AUX:     ma_w = (WORD_W + 1)'(aux);
      MA_ADDR:    ma_w = (WORD_W + 1)'(addr);
      MA_ADDR_P1: ma_w = (WORD_W + 1)'(addr) + 1'b1;
      MA_ADDR_M1: ma_w = (WORD_W + 1)'(addr) - 1'b1;
      MA_FP:      ma_w = (WORD_W + 1)'(fp);
      MA_FP_P1:   ma_w = (WORD_W + 1)'(fp) + 1'b1;
      MA_FP_H:    ma_w = (WORD_W + 1)'(fp) + HOFS;
      MA_FP_H1:   ma_w = (WORD_W + 1)'(fp) + HOFS + 1'b1;
      default:    ma_w = '0;
    endcase
  end
  assign ma = ma_w[MEM_AW-1:0];

  // single-port byte memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[ma] <= wd;
    if (cmd.mem_re) rd_data <= mem[ma];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp  <= SIZE_P;
      aux <= SIZE_P;
    end else begin
      unique case (cmd.sp_op)
        SP_HOLD: sp <= sp;
        SP_INC1: sp <= sp + 1'b1;
        SP_INC2: sp <= sp + 2'd2;
        SP_DEC1: sp <= sp - 1'b1;
        SP_DEC2: sp <= sp - 2'd2;
        default: sp <= sp;
      endcase
      if (cmd.aux_mark)     aux <= sp;
      else if (cmd.aux_inc) aux <= aux + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_data[OP_W-1:0];
      val  <= in_data[OP_W +: WORD_W];
      addr <= in_data[OP_W + WORD_W +: PTR_W];
      fp   <= WORD_W'(in_data[OP_W + WORD_W + PTR_W +: PTR_W]);
      cnt  <= '0;
    end else if (cmd.fp_link) begin
      fp  <= word;
      cnt <= cnt + 1'b1;
    end
    if (cmd.hi_load) hi <= rd_data;
  end

  always_comb begin
    unique case (cmd.res_sel)
      RES_ZERO: res_next = '0;
      RES_BYTE: res_next = WORD_W'(rd_data);
      RES_WORD: res_next = word;
      default:  res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_data   <= res_next;
      res_status <= cmd.res_status;
      res_found  <= cmd.res_found;
    end
    // sp is already final when the result leaves
    if (cmd.out_load) out_data <= {res_found, res_status, sp, res_data};
  end

  always_comb begin
    stat.op           = op;
    stat.sp_ge1       = sp != '0;
    stat.sp_ge2       = sp >= PTR_W'(2);
    stat.sp_lt        = sp < SIZE_P;
    stat.sp_word_ok   = ((PTR_W + 1)'(sp) + 1'b1) < (PTR_W + 1)'(STACK_SIZE);
    stat.aux_lt       = aux < SIZE_P;
    stat.addr_lt      = addr < SIZE_P;
    stat.addr_word_ok = ((PTR_W + 1)'(addr) + 1'b1) < (PTR_W + 1)'(STACK_SIZE);
    stat.addr_wr_ok   = (addr != '0) && (addr < SIZE_P);
    stat.fp_zero      = fp == '0;
    stat.cnt_max      = cnt >= CNT_W'(MAX_FRAMES);
    stat.fp_h_ok      = ((WORD_W + 1)'(fp) + HOFS + 1'b1) < SIZE_W;
    stat.fp_ok        = ((WORD_W + 1)'(fp) + 1'b1) < SIZE_W;
    stat.word_nz      = word != '0;
    stat.sp           = sp;
    stat.aux          = aux;
    stat.cnt          = cnt;
  end

endmodule

[hw/rtl/bsfe_ctrl.sv]
// Controller state machine: decodes the opcode, sequences memory accesses
// and the frame walk, and runs both stream handshakes. Depends on bsfe_pkg.
module bsfe_ctrl
  import bsfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  bsfe_stat_t stat,
  output bsfe_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_WR_HI = 4'd2;
  localparam logic [3:0] S_RD_B  = 4'd3;
  localparam logic [3:0] S_RD_H  = 4'd4;
  localparam logic [3:0] S_RD_W  = 4'd5;
  localparam logic [3:0] S_WCHK  = 4'd6;
  localparam logic [3:0] S_WH1   = 4'd7;
  localparam logic [3:0] S_WH2   = 4'd8;
  localparam logic [3:0] S_WL1   = 4'd9;
  localparam logic [3:0] S_WL2   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]      state, state_next;
  logic            out_free;
  logic            fin;
  logic [1:0]      fin_sel;
  logic [ST_W-1:0] fin_st;
  logic            fin_found;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    fin        = 1'b0;
    fin_sel    = RES_ZERO;
    fin_st     = ST_OK;
    fin_found  = 1'b0;

    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_PUSH8: begin
            if (stat.sp_ge1) begin
              cmd.mem_we = 1'b1;
              cmd.ma_sel = MA_SP_M1;
              cmd.sp_op  = SP_DEC1;
              fin        = 1'b1;
            end else begin
              fin    = 1'b1;
              fin_st = ST_OVF;
            end
          end
          OP_PUSH16: begin
            if (stat.sp_ge2) begin
              cmd.mem_we = 1'b1;
              cmd.ma_sel = MA_SP_M1;
              state_next = S_WR_HI;
            end else begin
              fin    = 1'b1;
              fin_st = ST_OVF;
            end
          end
          OP_WRITE16: begin
            if (stat.addr_wr_ok) begin
              cmd.mem_we = 1'b1;
              cmd.ma_sel = MA_ADDR;
              state_next = S_WR_HI;
            end else begin
              fin    = 1'b1;
              fin_st = ST_OVF;
            end
          end
          OP_POP8: begin
            if (stat.sp_lt) begin
              cmd.mem_re = 1'b1;
              cmd.ma_sel = MA_SP;
              state_next = S_RD_B;
            end else begin
              fin    = 1'b1;
              fin_st = ST_UNF;
            end
          end
          OP_POP_AUX8: begin
            if (stat.aux_lt) begin
              cmd.mem_re = 1'b1;
              cmd.ma_sel = MA_AUX;
              state_next = S_RD_B;
            end else begin
              fin    = 1'b1;
              fin_st = ST_UNF;
            end
          end
          OP_READ8: begin
            if (stat.addr_lt) begin
              cmd.mem_re = 1'b1;
              cmd.ma_sel = MA_ADDR;
              state_next = S_RD_B;
            end else begin
              fin    = 1'b1;
              fin_st = ST_UNF;
            end
          end
          OP_POP16: begin
            if (stat.sp_word_ok) begin
              cmd.mem_re = 1'b1;
              cmd.ma_sel = MA_SP;
              state_next = S_RD_H;
            end else begin
              fin    = 1'b1;
              fin_st = ST_UNF;
            end
          end
          OP_READ16: begin
            if (stat.addr_word_ok) begin
              cmd.mem_re = 1'b1;
              cmd.ma_sel = MA_ADDR;
              state_next = S_RD_H;
            end else begin
              fin    = 1'b1;
              fin_st = ST_UNF;
            end
          end
          OP_MARK_AUX: begin
            cmd.aux_mark = 1'b1;
            fin          = 1'b1;
          end
          OP_FIND: state_next = S_WCHK;
          default: fin = 1'b1;   // unused opcode: no effect
        endcase
      end
      S_WR_HI: begin
        cmd.mem_we = 1'b1;
        cmd.wd_hi  = 1'b1;
        if (stat.op == OP_PUSH16) begin
          cmd.ma_sel = MA_SP_M2;
          cmd.sp_op  = SP_DEC2;
        end else begin
          cmd.ma_sel = MA_ADDR_M1;
        end
        fin = 1'b1;
      end
      S_RD_B: begin
        if (stat.op == OP_POP8)     cmd.sp_op   = SP_INC1;
        if (stat.op == OP_POP_AUX8) cmd.aux_inc = 1'b1;
        fin     = 1'b1;
        fin_sel = RES_BYTE;
      end
      S_RD_H: begin
        cmd.hi_load = 1'b1;
        cmd.mem_re  = 1'b1;
        cmd.ma_sel  = (stat.op == OP_POP16) ? MA_SP_P1 : MA_ADDR_P1;
        state_next  = S_RD_W;
      end
      S_RD_W: begin
        if (stat.op == OP_POP16) cmd.sp_op = SP_INC2;
        fin     = 1'b1;
        fin_sel = RES_WORD;
      end
      S_WCHK: begin
        priority if (stat.fp_zero) begin
          fin = 1'b1;
        end else if (stat.cnt_max) begin
          fin    = 1'b1;
          fin_st = ST_LIMIT;
        end else if (!stat.fp_h_ok) begin
          fin    = 1'b1;
          fin_st = ST_UNF;
        end else begin
          cmd.mem_re = 1'b1;
          cmd.ma_sel = MA_FP_H;
          state_next = S_WH1;
        end
      end
      S_WH1: begin
        cmd.hi_load = 1'b1;
        cmd.mem_re  = 1'b1;
        cmd.ma_sel  = MA_FP_H1;
        state_next  = S_WH2;
      end
      S_WH2: begin
        priority if (stat.word_nz) begin
          fin       = 1'b1;
          fin_sel   = RES_WORD;
          fin_found = 1'b1;
        end else if (!stat.fp_ok) begin
          fin    = 1'b1;
          fin_st = ST_UNF;
        end else begin
          cmd.mem_re = 1'b1;
          cmd.ma_sel = MA_FP;
          state_next = S_WL1;
        end
      end
      S_WL1: begin
        cmd.hi_load = 1'b1;
        cmd.mem_re  = 1'b1;
        cmd.ma_sel  = MA_FP_P1;
        state_next  = S_WL2;
      end
      S_WL2: begin
        cmd.fp_link = 1'b1;
        state_next  = S_WCHK;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          s_tready     = 1'b1;
          if (s_tvalid) begin
            cmd.load   = 1'b1;
            state_next = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (fin) begin
      cmd.res_load   = 1'b1;
      cmd.res_sel    = fin_sel;
      cmd.res_status = fin_st;
      cmd.res_found  = fin_found;
      state_next     = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load)  m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

[hw/rtl/byte_stack_frame_engine_core.sv]
// Byte stack frame engine, top level. One result beat per input beat. Push8, mark_aux and
// unused ops finish on decode; push16 and write16 add a high-byte write; 8-bit pops and
// reads add a byte read, 16-bit ones a high and a low byte read; find_handler reads each
// frame's handler and link words. Single-port 4096x8 memory, one byte per cycle.
// Reset (rst, sync, active high): sp and aux pointer to 4096 (empty), no beat held;
// the stack memory is not cleared and no clearing pass runs.
module byte_stack_frame_engine_core
  import bsfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input beats
  input  logic               s_tvalid,
  output logic               s_tready,
  // opcode[3:0], value[19:4], address[32:20], frame_pointer[45:33], zero pad
  input  logic [IN_BUS-1:0]  s_tdata,
  // result beats
  output logic               m_tvalid,
  input  logic               m_tready,
  // data[15:0], stack_pointer_out[28:16], status[30:29], found[31]
  output logic [OUT_BUS-1:0] m_tdata
);

  bsfe_cmd_t        cmd;
  bsfe_stat_t       stat;
  logic [OUT_W-1:0] out_data;

  // sequencing: decode, memory access order, frame walk, handshakes
  bsfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memory, pointers, result and output register
  bsfe_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata[IN_W-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  assign m_tdata = OUT_BUS'(out_data);

  // ---------------------------------------------------------------------------
  // checks

  // one beat at a time: accept drops ready for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a beat is in progress");

  // pointers never leave 0..STACK_SIZE
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (stat.sp <= PTR_W'(STACK_SIZE)) && (stat.aux <= PTR_W'(STACK_SIZE)))
    else $error("stack or aux pointer out of range");

  // a handler is only reported with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_W-1] |-> m_tdata[OUT_W-2 -: ST_W] == ST_OK)
    else $error("found flag with error status");

  // link count stops at the frame limit
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.fp_link |-> stat.cnt < CNT_W'(MAX_FRAMES))
    else $error("frame walk went past the link limit");

endmodule
